// ===== rtl/pixel_writethrough_lcd_framebuffer_defines.svh =====
// ----------------------------------------------------------------------------
// Pixel write-through LCD frame buffer: shared assertion macros
// Clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_WRITETHROUGH_LCD_FRAMEBUFFER_DEFINES_SVH
`define PIXEL_WRITETHROUGH_LCD_FRAMEBUFFER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PWLF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PWLF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pwlf_pkg.sv =====
// ----------------------------------------------------------------------------
// pwlf_pkg
// Types and constants of the pixel write-through LCD frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package pwlf_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH = 128;
    localparam int PAGE_COUNT  = 8;
    localparam int HALF_WIDTH  = PANEL_WIDTH / 2;
    localparam int STORE_DEPTH = PAGE_COUNT * PANEL_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Geometry as sized values for compares against the 7-bit column
    localparam logic [8:0] PANEL_WIDTH_V = 9'(PANEL_WIDTH);
    localparam logic [8:0] HALF_WIDTH_V  = 9'(HALF_WIDTH);
    localparam logic [4:0] PAGE_COUNT_V  = 5'(PAGE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    // Field widths
    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int PAGE_W = 3;
    localparam int BYTE_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_CMD_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_CMD_BASE = 1'd1;
    localparam logic [7:0] PAGE_CMD_BASE_RST   = 8'd184;
    localparam logic [7:0] COLUMN_CMD_BASE_RST = 8'd64;

    // Pixel operation codes
    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_TOGGLE = 2'd2
    } req_type_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAGE,
        ST_COL,
        ST_DATA
    } state_t;

    // Frame store access from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/pwlf_store.sv =====
// ----------------------------------------------------------------------------
// pwlf_store
// Page-organized frame store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlf_store (
    input  wire logic                           aclk,
    input  wire pwlf_pkg::ram_req_t             ram_req,
    output logic [pwlf_pkg::BYTE_W-1:0]         ram_rdata
);

    logic [pwlf_pkg::BYTE_W-1:0] mem [pwlf_pkg::STORE_DEPTH];
    logic [pwlf_pkg::BYTE_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (ram_req.wr_en) begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
    end

    // Read port, registered, holds when not enabled
    always_ff @(posedge aclk) begin
        if (ram_req.rd_en) begin
            rdata_reg <= mem[ram_req.rd_addr];
        end
    end

    assign ram_rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/pwlf_seq.sv =====
// ----------------------------------------------------------------------------
// pwlf_seq
// Request sequencer: store clear sweep, read-modify-write, three bus writes.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlf_seq (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // pixel requests
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [15:0]                         s_tdata,   // x[6:0], y[12:7]
    input  wire logic [1:0]                          s_tuser,   // req_type[1:0]
    // bus writes
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // bus_byte[7:0]
    output logic [1:0]                               m_tuser,   // chip_select, is_data
    output logic                                     m_tlast,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [pwlf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwlf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // frame store
    output pwlf_pkg::ram_req_t                       ram_req,
    input  wire logic [pwlf_pkg::BYTE_W-1:0]         ram_rdata
);

    pwlf_pkg::state_t state_reg, state_next;

    logic [7:0] pg_base_reg;
    logic [7:0] col_base_reg;

    logic [pwlf_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic                        mod_pend_reg;
    logic [pwlf_pkg::ADDR_W-1:0] addr_reg;
    logic [2:0]                  bit_reg;
    pwlf_pkg::req_type_t         req_reg;
    logic                        cs_reg;
    logic [7:0]                  col_reg;
    logic [7:0]                  new_byte_reg;
    logic [7:0]                  out_byte_reg;

    // Decoded request fields
    logic [pwlf_pkg::X_W-1:0]    in_x;
    logic [pwlf_pkg::Y_W-1:0]    in_y;
    logic [pwlf_pkg::PAGE_W-1:0] in_page;
    pwlf_pkg::req_type_t         in_req;
    logic                        in_req_known;
    logic                        in_ok;
    logic                        in_take;
    logic [pwlf_pkg::ADDR_W-1:0] in_addr;
    logic                        in_cs;
    logic [7:0]                  in_col;
    logic [7:0]                  bit_mask;
    logic [7:0]                  mod_byte;

    assign in_x    = s_tdata[6:0];
    assign in_y    = s_tdata[12:7];
    assign in_page = in_y[5:3];
    assign in_req  = pwlf_pkg::req_type_t'(s_tuser);

    assign in_req_known = (in_req == pwlf_pkg::REQ_SET) || (in_req == pwlf_pkg::REQ_CLEAR)
                       || (in_req == pwlf_pkg::REQ_TOGGLE);
    assign in_ok = in_req_known && ({2'b00, in_x} < pwlf_pkg::PANEL_WIDTH_V)
                && ({2'b00, in_page} < pwlf_pkg::PAGE_COUNT_V);
    assign in_take = s_tvalid && s_tready;

    // Store index: page * width + column
    assign in_addr = pwlf_pkg::ADDR_W'(32'(in_page) * 32'(pwlf_pkg::PANEL_WIDTH)
                                       + 32'(in_x));

    // Controller half and column within it
    assign in_cs  = ({2'b00, in_x} >= pwlf_pkg::HALF_WIDTH_V);
    assign in_col = in_cs ? 8'({2'b00, in_x} - pwlf_pkg::HALF_WIDTH_V) : {1'b0, in_x};

    // Pixel update on the byte just read
    assign bit_mask = 8'd1 << bit_reg;
    always_comb begin
        case (req_reg)
            pwlf_pkg::REQ_SET:    mod_byte = ram_rdata | bit_mask;
            pwlf_pkg::REQ_CLEAR:  mod_byte = ram_rdata & ~bit_mask;
            pwlf_pkg::REQ_TOGGLE: mod_byte = ram_rdata ^ bit_mask;
            default:              mod_byte = ram_rdata;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pwlf_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == pwlf_pkg::LAST_ADDR) state_next = pwlf_pkg::ST_IDLE;
            end
            pwlf_pkg::ST_IDLE: begin
                if (s_tvalid && in_ok) state_next = pwlf_pkg::ST_PAGE;
            end
            pwlf_pkg::ST_PAGE: begin
                if (m_tready) state_next = pwlf_pkg::ST_COL;
            end
            pwlf_pkg::ST_COL: begin
                if (m_tready) state_next = pwlf_pkg::ST_DATA;
            end
            pwlf_pkg::ST_DATA: begin
                if (m_tready) begin
                    state_next = (s_tvalid && in_ok) ? pwlf_pkg::ST_PAGE : pwlf_pkg::ST_IDLE;
                end
            end
            default: state_next = pwlf_pkg::ST_IDLE;
        endcase
    end

    // Handshake and store port outputs
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tlast  = 1'b0;
        case (state_reg)
            pwlf_pkg::ST_IDLE: s_tready = 1'b1;
            pwlf_pkg::ST_PAGE: m_tvalid = 1'b1;
            pwlf_pkg::ST_COL:  m_tvalid = 1'b1;
            pwlf_pkg::ST_DATA: begin
                m_tvalid = 1'b1;
                m_tlast  = 1'b1;
                s_tready = m_tready;
            end
            default: ;
        endcase

        ram_req.rd_en   = in_take && in_ok;
        ram_req.rd_addr = in_addr;
        if (state_reg == pwlf_pkg::ST_CLEAR) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = clr_cnt_reg;
            ram_req.wr_data = '0;
        end else begin
            ram_req.wr_en   = mod_pend_reg;
            ram_req.wr_addr = addr_reg;
            ram_req.wr_data = mod_byte;
        end
    end

    assign m_tdata = out_byte_reg;
    assign m_tuser = {m_tlast, cs_reg};

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pwlf_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            mod_pend_reg <= 1'b0;
            pg_base_reg  <= pwlf_pkg::PAGE_CMD_BASE_RST;
            col_base_reg <= pwlf_pkg::COLUMN_CMD_BASE_RST;
        end else begin
            state_reg    <= state_next;
            mod_pend_reg <= in_take && in_ok;
            if (state_reg == pwlf_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    pwlf_pkg::REG_PAGE_CMD_BASE:   pg_base_reg  <= cfg_wdata;
                    pwlf_pkg::REG_COLUMN_CMD_BASE: col_base_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Request payload and output byte
    always_ff @(posedge aclk) begin
        if (in_take && in_ok) begin
            addr_reg     <= in_addr;
            bit_reg      <= in_y[2:0];
            req_reg      <= in_req;
            cs_reg       <= in_cs;
            col_reg      <= in_col;
            out_byte_reg <= pg_base_reg | {5'b00000, in_page};
        end else if (state_reg == pwlf_pkg::ST_PAGE && m_tready) begin
            out_byte_reg <= col_base_reg | col_reg;
        end else if (state_reg == pwlf_pkg::ST_COL && m_tready) begin
            out_byte_reg <= new_byte_reg;
        end
        if (mod_pend_reg) begin
            new_byte_reg <= mod_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pixel_writethrough_lcd_framebuffer.sv =====
// Latency: the page instruction is valid the cycle after a request is accepted.
// Requests: a new pixel request is accepted only in idle or as the data write
// leaves; the single output register carries the three bus writes in turn.
// The frame store is read once and written once per request over its one port pair.
// Reset: clearing pass over all 1024 frame store bytes, no requests taken meanwhile.
// Configuration registers return to 184 and 64.
// ----------------------------------------------------------------------------
// pixel_writethrough_lcd_framebuffer
// Pixel set/clear/toggle into a mono page frame store with panel bus writes.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_writethrough_lcd_framebuffer (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [15:0]                         s_tdata,   // x[6:0], y[12:7]
    input  wire logic [1:0]                          s_tuser,   // req_type[1:0]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // bus_byte[7:0]
    output logic [1:0]                               m_tuser,   // chip_select[0], is_data[1]
    output logic                                     m_tlast,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pwlf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwlf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    pwlf_pkg::ram_req_t          ram_req;
    logic [pwlf_pkg::BYTE_W-1:0] ram_rdata;

    // Sequencer
    pwlf_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Frame store
    pwlf_store u_store (
        .aclk      (aclk),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/pwlf_checker.sv =====
// ----------------------------------------------------------------------------
// pwlf_checker
// Port-level checks of the bus write runs, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_writethrough_lcd_framebuffer_defines.svh"

module pwlf_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic [1:0] m_tuser,
    input  wire logic       m_tlast
);

    // stalled bus write holds its byte
    `PWLF_ASSERT_NEXT(a_hold_byte, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "bus byte changed under stall")

    // only the data write ends a run
    `PWLF_ASSERT_SAME(a_last_is_data, aclk, aresetn, m_tvalid, m_tlast == m_tuser[1], "last and data flag disagree")

    // run continues straight after an instruction write
    `PWLF_ASSERT_NEXT(a_run_cont, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && $stable(m_tuser[0]), "run broken or chip select changed")

    // new request only while the run's data write leaves
    `PWLF_ASSERT_SAME(a_take_at_end, aclk, aresetn, s_tready && m_tvalid, m_tlast && m_tready, "request taken mid run")

    // no request taken and nothing pending: no bus write next cycle
    `PWLF_ASSERT_NEXT(a_no_spur, aclk, aresetn, !m_tvalid && !(s_tvalid && s_tready), !m_tvalid, "bus write without request")

endmodule

bind pixel_writethrough_lcd_framebuffer pwlf_checker u_pwlf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
